// ===== rtl/core/rabin_rolling_window_hash_assert.svh =====
// ----------------------------------------------------------------------------
// Rabin rolling hash assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RABIN_ROLLING_WINDOW_HASH_ASSERT_SVH
`define RABIN_ROLLING_WINDOW_HASH_ASSERT_SVH

// Same-cycle implication.
`define RRWH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RRWH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rrwh_pkg.sv =====
// ----------------------------------------------------------------------------
// Rabin rolling hash package
// Polynomial constants, GF(2) step functions and the constant reduction ROM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrwh_pkg;

    localparam logic [63:0] POLY     = 64'hbfe6b8a5bf378d83;
    localparam logic [63:0] TOP_BIT  = 64'h8000000000000000;
    localparam int          FP_W     = 63;
    localparam int          CSUM_W   = 32;
    localparam int          BYTE_W   = 8;
    localparam int          LEN_W    = 16;
    localparam int          TAB_DEPTH = 256;
    localparam logic [LEN_W-1:0] LEN_RESET = 16'd48;

    typedef logic [FP_W-1:0] fp_t;
    typedef fp_t red_rom_t [TAB_DEPTH];

    // Multiply a reduced value by x and fold bit 63 back in.
    function automatic fp_t times_x(input fp_t r);
        logic [63:0] t;
        t = {r, 1'b0};
        if (t[63])
        begin
            t = t ^ POLY;
        end
        return t[FP_W-1:0];
    endfunction

    // Entry j is j * x^63 mod POLY; evaluated only at elaboration.
    function automatic red_rom_t build_red_rom();
        red_rom_t rom;
        fp_t      r;
        fp_t      base;
        base = POLY[FP_W-1:0];
        for (int j = 0; j < TAB_DEPTH; j++)
        begin
            r = '0;
            for (int b = 7; b >= 0; b--)
            begin
                r = times_x(r);
                if (((j >> b) & 1) != 0)
                begin
                    r = r ^ base;
                end
            end
            rom[j] = r;
        end
        return rom;
    endfunction

    localparam red_rom_t RED_ROM = build_red_rom();

    // Multiply by x^8, insert a byte and reduce with the ROM.
    function automatic fp_t shift_in_byte(input fp_t p, input logic [BYTE_W-1:0] b);
        return {p[FP_W-BYTE_W-1:0], b} ^ RED_ROM[p[FP_W-1:FP_W-BYTE_W]];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rabin_rolling_window_hash.sv =====
// ----------------------------------------------------------------------------
// Rabin rolling window hash
// One rolling fingerprint step per beat, driven by a 256-entry table of
// leaving-byte contributions that is rebuilt whenever the window changes.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  src     | src_valid / src_stall | csum, out_byte, in_byte
//  dst     | dst_valid / dst_stall | new_csum
//  cfg     | cfg_valid / cfg_ready | window_len
//
//  One beat per cycle while src_stall is low; each result passes the
//  table-read stage, then the output register.
//  The table is built after reset and after each window_len write: the x^8
//  power loop, the per-bit weight steps and the 256-entry table fill run
//  in turn, and src_stall stays high meanwhile.
//  A stalled result holds the pipeline; outside table building, src_stall
//  rises only when both the table-read stage and the output register are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rabin_rolling_window_hash_assert.svh"

module rabin_rolling_window_hash
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          src_valid,
    output logic                               src_stall,
    input  wire logic [rrwh_pkg::CSUM_W-1:0]   csum,
    input  wire logic [rrwh_pkg::BYTE_W-1:0]   out_byte,
    input  wire logic [rrwh_pkg::BYTE_W-1:0]   in_byte,
    output logic                               dst_valid,
    input  wire logic                          dst_stall,
    output logic [rrwh_pkg::CSUM_W-1:0]        new_csum,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rrwh_pkg::LEN_W-1:0]    window_len
);

    typedef enum logic [3:0]
    {
        ST_POW  = 4'b0001,
        ST_BITS = 4'b0010,
        ST_FILL = 4'b0100,
        ST_RUN  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [rrwh_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [rrwh_pkg::LEN_W-1:0]     cnt_reg, cnt_next;
    rrwh_pkg::fp_t                  w_reg, w_next;
    logic [2:0]                     bit_reg, bit_next;
    logic [rrwh_pkg::BYTE_W-1:0]    idx_reg, idx_next;
    rrwh_pkg::fp_t                  bw_reg [8];

    logic                           s1_valid_reg, s1_valid_next;
    logic                           dst_valid_reg, dst_valid_next;
    logic [23:0]                    s1_csum_reg;
    logic [rrwh_pkg::BYTE_W-1:0]    s1_byte_reg;
    logic [rrwh_pkg::CSUM_W-1:0]    rd_data_reg;
    logic [rrwh_pkg::CSUM_W-1:0]    new_csum_reg;

    logic [rrwh_pkg::CSUM_W-1:0]    tab_mem [rrwh_pkg::TAB_DEPTH];

    rrwh_pkg::fp_t                  fill_weight;
    logic [rrwh_pkg::CSUM_W-1:0]    fill_data;
    logic                           fill_we;
    logic                           src_accept;
    logic                           s1_adv;

    assign cfg_ready  = 1'b1;
    assign src_stall  = (state_reg != ST_RUN) || (s1_valid_reg && dst_valid_reg && dst_stall);
    assign src_accept = src_valid && !src_stall;
    assign s1_adv     = s1_valid_reg && (!dst_valid_reg || !dst_stall);
    assign fill_we    = (state_reg == ST_FILL);
    assign dst_valid  = dst_valid_reg;
    assign new_csum   = new_csum_reg;

    // Contribution of a leaving byte is linear, so each table entry folds the
    // top-byte reduction of its weight into the low 32 bits in advance.
    always_comb
    begin
        fill_weight = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (idx_reg[b])
            begin
                fill_weight = fill_weight ^ bw_reg[b];
            end
        end
        fill_data = {fill_weight[23:0], 8'h00}
                  ^ rrwh_pkg::RED_ROM[fill_weight[62:55]][rrwh_pkg::CSUM_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        w_next     = w_reg;
        bit_next   = bit_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_POW:
            begin
                // A window length of zero behaves as length one.
                if (cnt_reg >= len_reg)
                begin
                    state_next = ST_BITS;
                    bit_next   = 3'd0;
                end
                else
                begin
                    w_next   = rrwh_pkg::shift_in_byte(w_reg, 8'h00);
                    cnt_next = cnt_reg + 16'd1;
                end
            end
            ST_BITS:
            begin
                w_next   = rrwh_pkg::times_x(w_reg);
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                begin
                    state_next = ST_FILL;
                    idx_next   = 8'd0;
                end
            end
            ST_FILL:
            begin
                idx_next = idx_reg + 8'd1;
                if (idx_reg == 8'hff)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_POW;
            end
        endcase
        if (cfg_valid)
        begin
            len_next   = window_len;
            state_next = ST_POW;
            cnt_next   = 16'd1;
            w_next     = rrwh_pkg::fp_t'(1);
        end
    end

    always_comb
    begin
        s1_valid_next  = src_accept || (s1_valid_reg && !s1_adv);
        dst_valid_next = s1_adv || (dst_valid_reg && dst_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_POW;
            len_reg       <= rrwh_pkg::LEN_RESET;
            cnt_reg       <= 16'd1;
            w_reg         <= rrwh_pkg::fp_t'(1);
            bit_reg       <= 3'd0;
            idx_reg       <= 8'd0;
            s1_valid_reg  <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            w_reg         <= w_next;
            bit_reg       <= bit_next;
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_BITS)
        begin
            bw_reg[bit_reg] <= w_reg;
        end
        if (src_accept)
        begin
            s1_csum_reg <= csum[23:0];
            s1_byte_reg <= in_byte;
        end
        if (s1_adv)
        begin
            new_csum_reg <= {s1_csum_reg, s1_byte_reg} ^ rd_data_reg;
        end
    end

    // Contribution table: written during the fill, read once per beat.
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            tab_mem[idx_reg] <= fill_data;
        end
        if (src_accept)
        begin
            rd_data_reg <= tab_mem[out_byte];
        end
    end

    `RRWH_ASSERT_NOW(a_accept_only_in_run, src_valid && !src_stall, state_reg == ST_RUN,
        "input beat accepted while the table is being built")
    `RRWH_ASSERT_NEXT(a_accept_fills_s1, src_valid && !src_stall, s1_valid_reg,
        "accepted beat did not reach the table-read stage")
    `RRWH_ASSERT_NEXT(a_blocked_s1_holds, s1_valid_reg && dst_valid_reg && dst_stall,
        s1_valid_reg && $stable(rd_data_reg) && $stable(s1_csum_reg),
        "blocked table-read stage lost its data")

endmodule

`default_nettype wire
